### rtl/pfsp_pkg.sv
package pfsp_pkg;

  localparam int VALUE_BITS_DEFAULT = 31;
  localparam int COUNT_BITS_DEFAULT = 8;
  localparam int FIELD_BITS         = 31;
  localparam int COUNT_OUT_BITS     = 8;
  localparam int COUNT_OUT_MAX      = 255;

  // parse stages
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FLAGS  = 4'd1;
  localparam logic [3:0] ST_WIDTH  = 4'd2;
  localparam logic [3:0] ST_PREC   = 4'd3;
  localparam logic [3:0] ST_PFIRST = 4'd4;
  localparam logic [3:0] ST_PDIG   = 4'd5;
  localparam logic [3:0] ST_LEN    = 4'd6;
  localparam logic [3:0] ST_LENH   = 4'd7;
  localparam logic [3:0] ST_LENL   = 4'd8;
  localparam logic [3:0] ST_CONV   = 4'd9;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_UNSUPPORTED = 2'd1;
  localparam logic [1:0] STAT_INVALID     = 2'd2;

  localparam logic [1:0] SIGN_NEG_ONLY = 2'd0;
  localparam logic [1:0] SIGN_PLUS     = 2'd1;
  localparam logic [1:0] SIGN_SPACE    = 2'd2;

  localparam int FLAG_LEFT      = 0;
  localparam int FLAG_PREFIX    = 1;
  localparam int FLAG_ZERO_PAD  = 2;
  localparam int FLAG_FRAC_ZERO = 3;
  localparam int FLAG_UNSIGNED  = 4;
  localparam int FLAG_UPPER     = 5;

  localparam logic [3:0] ARG_UNKNOWN    = 4'd0;
  localparam logic [3:0] ARG_CHAR       = 4'd1;
  localparam logic [3:0] ARG_BYTE       = 4'd2;
  localparam logic [3:0] ARG_SHORT      = 4'd3;
  localparam logic [3:0] ARG_INT        = 4'd4;
  localparam logic [3:0] ARG_LONG       = 4'd5;
  localparam logic [3:0] ARG_LONGLONG   = 4'd6;
  localparam logic [3:0] ARG_DOUBLE     = 4'd7;
  localparam logic [3:0] ARG_LONGDOUBLE = 4'd8;

  localparam logic [4:0] RADIX_NONE = 5'd0;
  localparam logic [4:0] RADIX_OCT  = 5'd8;
  localparam logic [4:0] RADIX_DEC  = 5'd10;
  localparam logic [4:0] RADIX_HEX  = 5'd16;

  localparam logic [1:0] NOTA_NONE   = 2'd0;
  localparam logic [1:0] NOTA_SCI    = 2'd1;
  localparam logic [1:0] NOTA_FIXED  = 2'd2;
  localparam logic [1:0] NOTA_SHORT  = 2'd3;

  localparam logic [3:0] LEN_NONE = 4'd0;
  localparam logic [3:0] LEN_HH   = 4'd1;
  localparam logic [3:0] LEN_H    = 4'd2;
  localparam logic [3:0] LEN_L    = 4'd3;
  localparam logic [3:0] LEN_LL   = 4'd4;
  localparam logic [3:0] LEN_J    = 4'd5;
  localparam logic [3:0] LEN_T    = 4'd6;
  localparam logic [3:0] LEN_Z    = 4'd7;
  localparam logic [3:0] LEN_BIGL = 4'd8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_L  = 8'h6C;
  localparam logic [7:0] CH_LC_J  = 8'h6A;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_L  = 8'h4C;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_UC_E  = 8'h45;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_G  = 8'h67;
  localparam logic [7:0] CH_UC_G  = 8'h47;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_P  = 8'h70;
  localparam logic [7:0] CH_LC_S  = 8'h73;

  typedef struct packed {
    logic [3:0] stage;
    logic [1:0] sign;
    logic [3:0] flags;
    logic [3:0] length;
  } ctrl_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [COUNT_OUT_BITS-1:0] chars_consumed;
    logic [1:0]                sign_mode;
    logic [5:0]                flag_bits;
    logic [FIELD_BITS-1:0]     min_width;
    logic [FIELD_BITS-1:0]     precision;
    logic [3:0]                arg_type;
    logic [4:0]                radix;
    logic [1:0]                notation;
    logic [3:0]                length_kind;
  } result_t;

endpackage

### rtl/pfsp_digit.sv
module pfsp_digit #(
  parameter int VALUE_BITS = 31
) (
  input  logic [VALUE_BITS-1:0] acc,
  input  logic [3:0]            digit,
  output logic [VALUE_BITS-1:0] sum,
  output logic                  overflow
);

  logic [VALUE_BITS+3:0] wide;

  // acc*10 + digit as (acc<<3) + (acc<<1) + digit
  assign wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VALUE_BITS + 4)'(digit);
  assign sum = wide[VALUE_BITS-1:0];
  assign overflow = |wide[VALUE_BITS+3:VALUE_BITS];

endmodule

### rtl/pfsp_step.sv
module pfsp_step #(
  parameter int VALUE_BITS = 31,
  parameter int COUNT_BITS = 8
) (
  input  pfsp_pkg::ctrl_t         ctrl,
  input  logic [COUNT_BITS-1:0]   char_count,
  input  logic [COUNT_BITS-1:0]   stage_start_count,
  input  logic [VALUE_BITS-1:0]   width_acc,
  input  logic [VALUE_BITS-1:0]   precision_acc,
  input  logic [7:0]              character,
  input  logic                    start_of_spec,
  input  logic                    enable_long_long,
  output pfsp_pkg::ctrl_t         ctrl_next,
  output logic [COUNT_BITS-1:0]   char_count_next,
  output logic [COUNT_BITS-1:0]   stage_start_count_next,
  output logic [VALUE_BITS-1:0]   width_acc_next,
  output logic [VALUE_BITS-1:0]   precision_acc_next,
  output logic                    has_result,
  output pfsp_pkg::result_t       result
);

  import pfsp_pkg::*;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  function automatic logic [COUNT_OUT_BITS-1:0] clamp_count(input logic [COUNT_BITS-1:0] v);
    if (32'(v) > COUNT_OUT_MAX) return COUNT_OUT_BITS'(COUNT_OUT_MAX);
    return COUNT_OUT_BITS'(v);
  endfunction

  ctrl_t                 base;
  logic [COUNT_BITS-1:0] base_cc;
  logic [COUNT_BITS-1:0] base_ssc;
  logic [VALUE_BITS-1:0] base_wacc;
  logic [VALUE_BITS-1:0] base_pacc;
  logic [COUNT_BITS-1:0] bumped;
  logic [VALUE_BITS-1:0] dig_acc;
  logic [VALUE_BITS-1:0] dig_sum;
  logic                  dig_ovf;
  logic                  is_digit;

  // a start clears the parse before the character is looked at
  always_comb begin
    if (start_of_spec) begin
      base.stage  = ST_FLAGS;
      base.sign   = SIGN_NEG_ONLY;
      base.flags  = '0;
      base.length = LEN_NONE;
      base_cc     = '0;
      base_ssc    = '0;
      base_wacc   = '0;
      base_pacc   = '0;
    end else begin
      base      = ctrl;
      base_cc   = char_count;
      base_ssc  = stage_start_count;
      base_wacc = width_acc;
      base_pacc = precision_acc;
    end
  end

  assign bumped   = (base_cc == COUNT_MAX) ? base_cc : base_cc + 1'b1;
  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign dig_acc  = (base.stage == ST_PFIRST || base.stage == ST_PDIG) ? base_pacc : base_wacc;

  pfsp_digit #(.VALUE_BITS(VALUE_BITS)) u_digit (
    .acc      (dig_acc),
    .digit    (character[3:0]),
    .sum      (dig_sum),
    .overflow (dig_ovf)
  );

  always_comb begin
    logic [3:0]            stg;
    logic                  done;
    logic                  fail;
    logic                  ok;
    logic [1:0]            fail_status;
    logic [5:0]            cv_flags;
    logic [4:0]            cv_radix;
    logic [1:0]            cv_nota;
    logic [3:0]            cv_type;
    logic                  cv_float;
    logic                  cv_num;

    stg                    = base.stage;
    ctrl_next              = base;
    char_count_next        = base_cc;
    stage_start_count_next = base_ssc;
    width_acc_next         = base_wacc;
    precision_acc_next     = base_pacc;
    done                   = (base.stage == ST_IDLE);
    fail                   = 1'b0;
    ok                     = 1'b0;
    fail_status            = STAT_INVALID;
    cv_flags               = {2'b00, base.flags};
    cv_radix               = RADIX_DEC;
    cv_nota                = NOTA_NONE;
    cv_type                = ARG_UNKNOWN;
    cv_float               = 1'b0;
    cv_num                 = 1'b0;

    if (!done && stg == ST_FLAGS) begin
      done = 1'b1;
      priority if (character == CH_MINUS) ctrl_next.flags[FLAG_LEFT] = 1'b1;
      else if (character == CH_HASH) ctrl_next.flags[FLAG_PREFIX] = 1'b1;
      else if (character == CH_ZERO) ctrl_next.flags[FLAG_ZERO_PAD] = 1'b1;
      else if (character == CH_PLUS) ctrl_next.sign = SIGN_PLUS;
      else if (character == CH_SPACE) ctrl_next.sign = SIGN_SPACE;
      else begin
        done = 1'b0;
        stg  = ST_WIDTH;
      end
      if (done) char_count_next = bumped;
    end

    if (!done && stg == ST_WIDTH) begin
      if (is_digit) begin
        width_acc_next  = dig_ovf ? VALUE_MAX : dig_sum;
        char_count_next = bumped;
        done            = 1'b1;
      end else begin
        stg = ST_PREC;
      end
    end

    if (!done && stg == ST_PREC) begin
      stage_start_count_next = base_cc;
      if (character == CH_DOT) begin
        char_count_next = bumped;
        stg             = ST_PFIRST;
        done            = 1'b1;
      end else begin
        stg = ST_LEN;
      end
    end

    if (!done && stg == ST_PFIRST) begin
      stg = ST_PDIG;
      if (character == CH_ZERO) begin
        ctrl_next.flags[FLAG_FRAC_ZERO] = 1'b1;
        char_count_next = bumped;
        done            = 1'b1;
      end
    end

    if (!done && stg == ST_PDIG) begin
      if (is_digit) begin
        done = 1'b1;
        if (dig_ovf) begin
          // precision overflow reports a zero precision
          precision_acc_next = '0;
          fail               = 1'b1;
        end else begin
          precision_acc_next = dig_sum;
          char_count_next    = bumped;
        end
      end else begin
        stage_start_count_next = base_cc;
        stg                    = ST_LEN;
      end
    end

    if (!done && stg == ST_LEN) begin
      stg  = ST_CONV;
      done = 1'b1;
      unique case (character)
        CH_LC_H: begin
          ctrl_next.length = LEN_H;
          stg              = ST_LENH;
        end
        CH_LC_L: begin
          ctrl_next.length = LEN_L;
          if (enable_long_long) stg = ST_LENL;
        end
        CH_LC_J: ctrl_next.length = LEN_J;
        CH_LC_T: ctrl_next.length = LEN_T;
        CH_LC_Z: ctrl_next.length = LEN_Z;
        CH_UC_L: ctrl_next.length = LEN_BIGL;
        CH_NUL:  fail = 1'b1;
        default: begin
          ctrl_next.length = LEN_NONE;
          done             = 1'b0;
        end
      endcase
      if (done && !fail) char_count_next = bumped;
    end

    if (!done && (stg == ST_LENH || stg == ST_LENL)) begin
      if (stg == ST_LENH && character == CH_LC_H) begin
        ctrl_next.length = LEN_HH;
        char_count_next  = bumped;
        done             = 1'b1;
      end else if (stg == ST_LENL && character == CH_LC_L) begin
        ctrl_next.length = LEN_LL;
        char_count_next  = bumped;
        done             = 1'b1;
      end
      stg = ST_CONV;
    end

    if (!done && stg == ST_CONV) begin
      done = 1'b1;
      unique case (character)
        CH_LC_C: begin
          cv_type  = ARG_CHAR;
          cv_radix = RADIX_NONE;
        end
        CH_LC_D, CH_LC_I: cv_num = 1'b1;
        CH_LC_U: begin
          cv_num                  = 1'b1;
          cv_flags[FLAG_UNSIGNED] = 1'b1;
        end
        CH_LC_O: begin
          cv_num                  = 1'b1;
          cv_flags[FLAG_UNSIGNED] = 1'b1;
          cv_radix                = RADIX_OCT;
        end
        CH_UC_X: begin
          cv_num                  = 1'b1;
          cv_flags[FLAG_UNSIGNED] = 1'b1;
          cv_flags[FLAG_UPPER]    = 1'b1;
          cv_radix                = RADIX_HEX;
        end
        CH_LC_X: begin
          cv_num                  = 1'b1;
          cv_flags[FLAG_UNSIGNED] = 1'b1;
          cv_radix                = RADIX_HEX;
        end
        CH_UC_A, CH_LC_A: begin
          cv_float             = 1'b1;
          cv_flags[FLAG_UPPER] = (character == CH_UC_A);
          cv_radix             = RADIX_HEX;
          cv_nota              = NOTA_SCI;
        end
        CH_UC_E, CH_LC_E: begin
          cv_float             = 1'b1;
          cv_flags[FLAG_UPPER] = (character == CH_UC_E);
          cv_nota              = NOTA_SCI;
        end
        CH_UC_F, CH_LC_F: begin
          cv_float             = 1'b1;
          cv_flags[FLAG_UPPER] = (character == CH_UC_F);
          cv_nota              = NOTA_FIXED;
        end
        CH_UC_G, CH_LC_G: begin
          cv_float             = 1'b1;
          cv_flags[FLAG_UPPER] = (character == CH_UC_G);
          cv_nota              = NOTA_SHORT;
        end
        CH_LC_N, CH_LC_P, CH_LC_S: begin
          fail        = 1'b1;
          fail_status = STAT_UNSUPPORTED;
        end
        default: fail = 1'b1;
      endcase

      if (cv_num) begin
        unique case (ctrl_next.length)
          LEN_NONE: cv_type = ARG_INT;
          LEN_HH:   cv_type = ARG_BYTE;
          LEN_H:    cv_type = ARG_SHORT;
          LEN_L:    cv_type = ARG_LONG;
          LEN_LL:   cv_type = enable_long_long ? ARG_LONGLONG : ARG_UNKNOWN;
          default:  cv_type = ARG_UNKNOWN;
        endcase
      end else if (cv_float) begin
        if (ctrl_next.length == LEN_NONE) cv_type = ARG_DOUBLE;
        else if (ctrl_next.length == LEN_BIGL && enable_long_long) cv_type = ARG_LONGDOUBLE;
        else cv_type = ARG_UNKNOWN;
      end

      if (!fail && cv_type == ARG_UNKNOWN) fail = 1'b1;
      if (!fail) begin
        ok              = 1'b1;
        char_count_next = bumped;
      end
    end

    ctrl_next.stage = (fail || ok) ? ST_IDLE : stg;
    has_result      = fail || ok;

    result.status         = ok ? STAT_OK : fail_status;
    result.chars_consumed = ok ? clamp_count(char_count_next)
                               : clamp_count(stage_start_count_next);
    result.sign_mode      = ctrl_next.sign;
    result.flag_bits      = ok ? cv_flags : {2'b00, ctrl_next.flags};
    result.min_width      = FIELD_BITS'(width_acc_next);
    result.precision      = FIELD_BITS'(precision_acc_next);
    result.arg_type       = ok ? cv_type : ARG_UNKNOWN;
    result.radix          = ok ? cv_radix : RADIX_NONE;
    result.notation       = ok ? cv_nota : NOTA_NONE;
    result.length_kind    = ctrl_next.length;
  end

endmodule

### rtl/printf_format_spec_parser_unit.sv
// printf conversion-spec parser
// feed the bytes after a percent sign on the input channel, one per transaction,
// with start_of_spec set on the first one; bytes outside a spec are dropped
// the parse walks flags, width, '.' precision, length modifier and conversion
// letter; exactly one result transaction leaves per spec, on the conversion
// letter or at the first byte that makes the spec invalid
// a byte passes the input register, then the result register, before
// out_valid; throughput: one byte per cycle while in_stall is low, as the
// state update with its multiply-by-ten digit adder is combinational
// a byte is taken while a result waits on a stalled output; in_stall rises
// only when the registered byte completes a spec and the result register is
// still full and stalled
// cfg_write_enable/cfg_write_data load enable_long_long (1 accepts ll and L);
// write it only while no spec is in flight
// rst (synchronous) empties both registers, clears the parse to idle and
// sets enable_long_long
module printf_format_spec_parser_unit #(
  parameter int VALUE_BITS = pfsp_pkg::VALUE_BITS_DEFAULT,
  parameter int COUNT_BITS = pfsp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  input  logic        start_of_spec,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  chars_consumed,
  output logic [1:0]  sign_mode,
  output logic [5:0]  flag_bits,
  output logic [30:0] min_width,
  output logic [30:0] precision,
  output logic [3:0]  arg_type,
  output logic [4:0]  radix,
  output logic [1:0]  notation,
  output logic [3:0]  length_kind
);

  import pfsp_pkg::*;

  logic                  enable_long_long;
  logic                  s1_valid;
  logic [7:0]            s1_char;
  logic                  s1_start;
  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  logic [COUNT_BITS-1:0] char_count;
  logic [COUNT_BITS-1:0] char_count_next;
  logic [COUNT_BITS-1:0] stage_start_count;
  logic [COUNT_BITS-1:0] stage_start_count_next;
  logic [VALUE_BITS-1:0] width_acc;
  logic [VALUE_BITS-1:0] width_acc_next;
  logic [VALUE_BITS-1:0] precision_acc;
  logic [VALUE_BITS-1:0] precision_acc_next;
  logic                  step_has_result;
  result_t               step_result;
  result_t               out_result;
  logic                  s1_go;

  pfsp_step #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)) u_step (
    .ctrl                   (ctrl),
    .char_count             (char_count),
    .stage_start_count      (stage_start_count),
    .width_acc              (width_acc),
    .precision_acc          (precision_acc),
    .character              (s1_char),
    .start_of_spec          (s1_start),
    .enable_long_long       (enable_long_long),
    .ctrl_next              (ctrl_next),
    .char_count_next        (char_count_next),
    .stage_start_count_next (stage_start_count_next),
    .width_acc_next         (width_acc_next),
    .precision_acc_next     (precision_acc_next),
    .has_result             (step_has_result),
    .result                 (step_result)
  );

  // the registered byte moves on unless it needs the result register while that is full and stalled
  assign s1_go    = !step_has_result || !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_long_long <= 1'b1;
    end else if (cfg_write_enable) begin
      enable_long_long <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_char  <= character;
      s1_start <= start_of_spec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.stage        <= ST_IDLE;
      ctrl.sign         <= SIGN_NEG_ONLY;
      ctrl.flags        <= '0;
      ctrl.length       <= LEN_NONE;
      char_count        <= '0;
      stage_start_count <= '0;
      width_acc         <= '0;
      precision_acc     <= '0;
    end else if (s1_valid && s1_go) begin
      ctrl              <= ctrl_next;
      char_count        <= char_count_next;
      stage_start_count <= stage_start_count_next;
      width_acc         <= width_acc_next;
      precision_acc     <= precision_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_go && step_has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go && step_has_result) begin
      out_result <= step_result;
    end
  end

  assign status         = out_result.status;
  assign chars_consumed = out_result.chars_consumed;
  assign sign_mode      = out_result.sign_mode;
  assign flag_bits      = out_result.flag_bits;
  assign min_width      = out_result.min_width;
  assign precision      = out_result.precision;
  assign arg_type       = out_result.arg_type;
  assign radix          = out_result.radix;
  assign notation       = out_result.notation;
  assign length_kind    = out_result.length_kind;

  a_reset_empties: assert property (@(posedge clk) $past(rst) |-> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_error_untyped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_OK) |->
      (arg_type == ARG_UNKNOWN && radix == RADIX_NONE && notation == NOTA_NONE &&
       flag_bits[5:4] == 2'b00))
    else $error("error result carries a conversion type");

  a_ok_typed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_OK) |-> arg_type != ARG_UNKNOWN)
    else $error("ok result without an argument type");

  a_blocked_byte_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && step_has_result && out_valid && out_stall) |=>
      (s1_valid && $stable(s1_char) && $stable(s1_start) && $stable(ctrl)))
    else $error("completing byte lost while result register was blocked");

endmodule

### test/printf_format_spec_parser_unit_tb.sv
module printf_format_spec_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfsp_pkg::*;

  localparam longint unsigned VALUE_LIMIT = (64'd1 << 31) - 1;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        cfg_write_enable;
  logic        cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  character;
  logic        start_of_spec;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [7:0]  chars_consumed;
  logic [1:0]  sign_mode;
  logic [5:0]  flag_bits;
  logic [30:0] min_width;
  logic [30:0] precision;
  logic [3:0]  arg_type;
  logic [4:0]  radix;
  logic [1:0]  notation;
  logic [3:0]  length_kind;

  printf_format_spec_parser_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .character        (character),
    .start_of_spec    (start_of_spec),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .chars_consumed   (chars_consumed),
    .sign_mode        (sign_mode),
    .flag_bits        (flag_bits),
    .min_width        (min_width),
    .precision        (precision),
    .arg_type         (arg_type),
    .radix            (radix),
    .notation         (notation),
    .length_kind      (length_kind)
  );

  // parser state as seen by the predictor
  logic [3:0]  spec_stage;
  logic [7:0]  spec_count;
  logic [7:0]  spec_mark;
  logic [1:0]  spec_sign;
  logic [3:0]  spec_flags;
  logic [30:0] spec_width;
  logic [30:0] spec_prec;
  logic [3:0]  spec_len;
  bit          long_long_on;

  result_t     pending_specs[$];
  logic [7:0]  spec_text[$];
  int          error_count;
  int          results_checked;
  int          parsed_chars;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_off_len;
  int          quiet_cycles;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void count_up();
    if (spec_count != 8'hFF) spec_count++;
  endfunction

  function automatic bit mul10_add(inout logic [30:0] acc, input logic [7:0] c);
    longint unsigned sum;
    sum = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
    if (sum > VALUE_LIMIT) return 0;
    acc = sum[30:0];
    return 1;
  endfunction

  function automatic void make_result(output result_t r, input logic [1:0] st,
                                      input logic [7:0] cnt, input logic [5:0] fl,
                                      input logic [3:0] at, input logic [4:0] rdx,
                                      input logic [1:0] nt);
    r.status         = st;
    r.chars_consumed = cnt;
    r.sign_mode      = spec_sign;
    r.flag_bits      = fl;
    r.min_width      = spec_width;
    r.precision      = spec_prec;
    r.arg_type       = at;
    r.radix          = rdx;
    r.notation       = nt;
    r.length_kind    = spec_len;
    spec_stage       = ST_IDLE;
  endfunction

  // errors report the count at the start of the failing stage and drop type info
  function automatic void spec_error(output result_t r, input logic [1:0] st);
    make_result(r, st, spec_mark, {2'b00, spec_flags}, ARG_UNKNOWN, RADIX_NONE, NOTA_NONE);
  endfunction

  function automatic void finish_conversion(input logic [7:0] c, output result_t r);
    logic [5:0] fl;
    logic [4:0] rdx;
    logic [1:0] nt;
    logic [3:0] at;
    bit         is_float;
    fl = {2'b00, spec_flags};
    rdx = RADIX_DEC;
    nt = NOTA_NONE;
    is_float = 0;
    case (c)
      CH_LC_C: begin
        count_up();
        make_result(r, STAT_OK, spec_count, fl, ARG_CHAR, RADIX_NONE, NOTA_NONE);
        return;
      end
      CH_LC_D, CH_LC_I: ;
      CH_LC_U: fl[FLAG_UNSIGNED] = 1;
      CH_LC_O: begin
        fl[FLAG_UNSIGNED] = 1;
        rdx = RADIX_OCT;
      end
      CH_UC_X: begin
        fl[FLAG_UNSIGNED] = 1;
        fl[FLAG_UPPER] = 1;
        rdx = RADIX_HEX;
      end
      CH_LC_X: begin
        fl[FLAG_UNSIGNED] = 1;
        rdx = RADIX_HEX;
      end
      CH_UC_A, CH_LC_A: begin
        fl[FLAG_UPPER] = (c == CH_UC_A);
        rdx = RADIX_HEX;
        nt = NOTA_SCI;
        is_float = 1;
      end
      CH_UC_E, CH_LC_E: begin
        fl[FLAG_UPPER] = (c == CH_UC_E);
        nt = NOTA_SCI;
        is_float = 1;
      end
      CH_UC_F, CH_LC_F: begin
        fl[FLAG_UPPER] = (c == CH_UC_F);
        nt = NOTA_FIXED;
        is_float = 1;
      end
      CH_UC_G, CH_LC_G: begin
        fl[FLAG_UPPER] = (c == CH_UC_G);
        nt = NOTA_SHORT;
        is_float = 1;
      end
      CH_LC_N, CH_LC_P, CH_LC_S: begin
        spec_error(r, STAT_UNSUPPORTED);
        return;
      end
      default: begin
        spec_error(r, STAT_INVALID);
        return;
      end
    endcase
    if (is_float) begin
      if (spec_len == LEN_NONE) at = ARG_DOUBLE;
      else if (spec_len == LEN_BIGL && long_long_on) at = ARG_LONGDOUBLE;
      else at = ARG_UNKNOWN;
    end else begin
      case (spec_len)
        LEN_NONE: at = ARG_INT;
        LEN_HH:   at = ARG_BYTE;
        LEN_H:    at = ARG_SHORT;
        LEN_L:    at = ARG_LONG;
        LEN_LL:   at = long_long_on ? ARG_LONGLONG : ARG_UNKNOWN;
        default:  at = ARG_UNKNOWN;
      endcase
    end
    if (at == ARG_UNKNOWN) begin
      spec_error(r, STAT_INVALID);
    end else begin
      count_up();
      make_result(r, STAT_OK, spec_count, fl, at, rdx, nt);
    end
  endfunction

  // returns 1 when this character completes or kills the spec
  function automatic bit parse_spec_char(input logic [7:0] c, input bit sos,
                                         output result_t r);
    bit done;
    bit made;
    r = '0;
    made = 0;
    if (sos) begin
      spec_stage = ST_FLAGS;
      spec_count = '0;
      spec_mark = '0;
      spec_sign = SIGN_NEG_ONLY;
      spec_flags = '0;
      spec_width = '0;
      spec_prec = '0;
      spec_len = LEN_NONE;
    end
    done = (spec_stage == ST_IDLE);
    // a character that ends one stage is offered again to the next
    while (!done) begin
      done = 1;
      case (spec_stage)
        ST_FLAGS: begin
          if (c == CH_MINUS) spec_flags[FLAG_LEFT] = 1;
          else if (c == CH_HASH) spec_flags[FLAG_PREFIX] = 1;
          else if (c == CH_ZERO) spec_flags[FLAG_ZERO_PAD] = 1;
          else if (c == CH_PLUS) spec_sign = SIGN_PLUS;
          else if (c == CH_SPACE) spec_sign = SIGN_SPACE;
          else begin
            spec_stage = ST_WIDTH;
            done = 0;
          end
          if (done) count_up();
        end
        ST_WIDTH: begin
          if (!is_digit(c)) begin
            spec_stage = ST_PREC;
            done = 0;
          end else begin
            if (!mul10_add(spec_width, c)) spec_width = '1;
            count_up();
          end
        end
        ST_PREC: begin
          spec_mark = spec_count;
          if (c == CH_DOT) begin
            count_up();
            spec_stage = ST_PFIRST;
          end else begin
            spec_stage = ST_LEN;
            done = 0;
          end
        end
        ST_PFIRST: begin
          spec_stage = ST_PDIG;
          if (c == CH_ZERO) begin
            spec_flags[FLAG_FRAC_ZERO] = 1;
            count_up();
          end else begin
            done = 0;
          end
        end
        ST_PDIG: begin
          if (is_digit(c)) begin
            if (!mul10_add(spec_prec, c)) begin
              spec_prec = '0;
              spec_error(r, STAT_INVALID);
              made = 1;
            end else begin
              count_up();
            end
          end else begin
            spec_mark = spec_count;
            spec_stage = ST_LEN;
            done = 0;
          end
        end
        ST_LEN: begin
          spec_stage = ST_CONV;
          case (c)
            CH_LC_H: begin
              spec_len = LEN_H;
              spec_stage = ST_LENH;
            end
            CH_LC_L: begin
              spec_len = LEN_L;
              if (long_long_on) spec_stage = ST_LENL;
            end
            CH_LC_J: spec_len = LEN_J;
            CH_LC_T: spec_len = LEN_T;
            CH_LC_Z: spec_len = LEN_Z;
            CH_UC_L: spec_len = LEN_BIGL;
            CH_NUL: begin
              spec_error(r, STAT_INVALID);
              made = 1;
            end
            default: begin
              spec_len = LEN_NONE;
              done = 0;
            end
          endcase
          if (done && !made) count_up();
        end
        ST_LENH, ST_LENL: begin
          if (c == ((spec_stage == ST_LENH) ? CH_LC_H : CH_LC_L)) begin
            spec_len = (spec_stage == ST_LENH) ? LEN_HH : LEN_LL;
            spec_stage = ST_CONV;
            count_up();
          end else begin
            spec_stage = ST_CONV;
            done = 0;
          end
        end
        ST_CONV: begin
          finish_conversion(c, r);
          made = 1;
        end
        default: ;
      endcase
    end
    return made;
  endfunction

  task automatic send_char(input logic [7:0] c, input bit sos);
    result_t spec_result;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    character = c;
    start_of_spec = sos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sos || spec_stage != ST_IDLE) parsed_chars++;
    if (parse_spec_char(c, sos, spec_result)) pending_specs.push_back(spec_result);
  endtask

  task automatic send_spec_text();
    for (int i = 0; i < spec_text.size(); i++) send_char(spec_text[i], i == 0);
  endtask

  task automatic send_string(input string s);
    spec_text.delete();
    for (int i = 0; i < s.len(); i++) spec_text.push_back(s[i]);
    send_spec_text();
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 0;
    while (pending_specs.size() != 0) @(posedge clk);
    // ignored bytes may still sit in the input register stage
    repeat (4) @(posedge clk);
  endtask

  task automatic write_long_long(input bit value);
    // a terminator closes any open spec from whatever stage it is in
    if (spec_stage != ST_IDLE) send_char(CH_NUL, 0);
    wait_for_results();
    @(negedge clk);
    cfg_write_enable = 1;
    cfg_write_data = value;
    @(negedge clk);
    cfg_write_enable = 0;
    long_long_on = value;
  endtask

  function automatic void push_digits(input int n);
    repeat (n) spec_text.push_back(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void build_random_spec();
    spec_text.delete();
    if ($urandom_range(1)) begin
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(4))
          0: spec_text.push_back(CH_MINUS);
          1: spec_text.push_back(CH_PLUS);
          2: spec_text.push_back(CH_SPACE);
          3: spec_text.push_back(CH_HASH);
          default: spec_text.push_back(CH_ZERO);
        endcase
      end
    end
    case ($urandom_range(9))
      5, 6, 7, 8: begin
        spec_text.push_back(CH_ZERO + 8'($urandom_range(9, 1)));
        push_digits($urandom_range(2));
      end
      9: begin
        // long widths can saturate
        spec_text.push_back(CH_ZERO + 8'($urandom_range(9, 1)));
        push_digits($urandom_range(11, 9));
      end
      default: ;
    endcase
    if ($urandom_range(9) < 4) begin
      spec_text.push_back(CH_DOT);
      if ($urandom_range(3) == 0) spec_text.push_back(CH_ZERO);
      if ($urandom_range(9) == 0) push_digits($urandom_range(11, 9));
      else push_digits($urandom_range(3));
    end
    case ($urandom_range(15))
      0: spec_text.push_back(CH_LC_H);
      1: begin
        spec_text.push_back(CH_LC_H);
        spec_text.push_back(CH_LC_H);
      end
      2: spec_text.push_back(CH_LC_L);
      3: begin
        spec_text.push_back(CH_LC_L);
        spec_text.push_back(CH_LC_L);
      end
      4: spec_text.push_back(CH_LC_J);
      5: spec_text.push_back(CH_LC_T);
      6: spec_text.push_back(CH_LC_Z);
      7: spec_text.push_back(CH_UC_L);
      default: ;
    endcase
    if ($urandom_range(9) == 0) begin
      spec_text.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(17))
        0:  spec_text.push_back(CH_LC_C);
        1:  spec_text.push_back(CH_LC_D);
        2:  spec_text.push_back(CH_LC_I);
        3:  spec_text.push_back(CH_LC_U);
        4:  spec_text.push_back(CH_LC_O);
        5:  spec_text.push_back(CH_LC_X);
        6:  spec_text.push_back(CH_UC_X);
        7:  spec_text.push_back(CH_LC_A);
        8:  spec_text.push_back(CH_UC_A);
        9:  spec_text.push_back(CH_LC_E);
        10: spec_text.push_back(CH_UC_E);
        11: spec_text.push_back(CH_LC_F);
        12: spec_text.push_back(CH_UC_F);
        13: spec_text.push_back(CH_LC_G);
        14: spec_text.push_back(CH_UC_G);
        15: spec_text.push_back(CH_LC_N);
        16: spec_text.push_back(CH_LC_P);
        default: spec_text.push_back(CH_LC_S);
      endcase
    end
  endfunction

  task automatic send_random_spec();
    int mode;
    int cut;
    mode = $urandom_range(99);
    if (mode < 90) begin
      build_random_spec();
      if (mode >= 78) begin
        // broken spec: cut short, then a terminator or a stray byte
        cut = $urandom_range(spec_text.size(), 1);
        while (spec_text.size() > cut) void'(spec_text.pop_back());
        if ($urandom_range(1)) spec_text.push_back(CH_NUL);
        else spec_text.push_back(8'($urandom_range(255)));
      end
      send_spec_text();
    end else begin
      repeat ($urandom_range(6, 1)) send_char(8'($urandom_range(255)), $urandom_range(4) == 0);
    end
    if ($urandom_range(4) == 0) send_char(8'($urandom_range(255)), 0);
  endtask

  task automatic test_idle_and_terminator();
    send_char(8'hFF, 0);
    send_char(CH_NUL, 1);
  endtask

  task automatic test_all_flags();
    send_string("- #0+.0hhX");
  endtask

  task automatic test_precision_overflow();
    send_string(".3000000000d");
  endtask

  task automatic test_unsupported_conversion();
    send_string("s");
  endtask

  task automatic test_long_l_split();
    send_string("lld");
    send_string("Lf");
    send_string("ld");
  endtask

  task automatic test_random_specs(input int char_goal);
    while (parsed_chars < char_goal) send_random_spec();
  endtask

  task automatic test_steady_stream(input int char_goal);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_specs(char_goal);
    tx_idle_pct = 19;
    rx_idle_pct = 19;
  endtask

  task automatic test_output_hold_off();
    hold_off_len = 300;
    repeat (24) send_char(CH_LC_D, 1);
  endtask

  task automatic test_sender_pause();
    wait_for_results();
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        out_stall = 1;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
      end
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin : result_checker
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_specs.size() == 0) begin
          $error("result transaction with no spec pending");
          error_count++;
        end else begin
          want = pending_specs.pop_front();
          check_field("status", want.status, status);
          check_field("chars_consumed", want.chars_consumed, chars_consumed);
          check_field("sign_mode", want.sign_mode, sign_mode);
          check_field("flag_bits", want.flag_bits, flag_bits);
          check_field("min_width", want.min_width, min_width);
          check_field("precision", want.precision, precision);
          check_field("arg_type", want.arg_type, arg_type);
          check_field("radix", want.radix, radix);
          check_field("notation", want.notation, notation);
          check_field("length_kind", want.length_kind, length_kind);
          results_checked++;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("[printf_format_spec_parser_unit] ERROR");
    $finish;
  end

  initial begin
    rst = 1;
    cfg_write_enable = 0;
    cfg_write_data = 0;
    in_valid = 0;
    character = '0;
    start_of_spec = 0;
    error_count = 0;
    results_checked = 0;
    parsed_chars = 0;
    tx_idle_pct = 19;
    rx_idle_pct = 19;
    hold_off_len = 0;
    long_long_on = 1;
    spec_stage = ST_IDLE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_long_long(1);
    test_idle_and_terminator();
    test_all_flags();
    test_precision_overflow();
    test_unsupported_conversion();
    test_steady_stream(parsed_chars + 150);
    test_random_specs(350);

    write_long_long(0);
    test_long_l_split();
    test_random_specs(650);

    write_long_long(1);
    test_output_hold_off();
    test_sender_pause();
    test_random_specs(1100);
    wait_for_results();

    $display("parsed %0d spec characters, checked %0d results, long-long on and off",
             parsed_chars, results_checked);
    if (error_count == 0) begin
      $display("[printf_format_spec_parser_unit] OK");
    end else begin
      $display("[printf_format_spec_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pfsp_pkg.sv
rtl/pfsp_digit.sv
rtl/pfsp_step.sv
rtl/printf_format_spec_parser_unit.sv
test/printf_format_spec_parser_unit_tb.sv
